/* sv/retenc_pkg.sv */
// Package for the REMB estimate throttle and encoder.
// Holds shared constants, status codes and controller/datapath structs.
// No dependencies.
package retenc_pkg;

    localparam int TABLE_DEPTH_DEF = 64;
    localparam logic [31:0] KBPS_CAP = 32'd4294967;
    localparam logic [17:0] MANT_MAX = 18'h3FFFF;
    localparam logic [5:0] EXP_MAX = 6'd63;
    localparam logic [15:0] MIN_INTERVAL_RST = 16'd500;
    localparam logic [6:0] MIN_CHANGE_RST = 7'd5;

    localparam logic [2:0] ST_SENT = 3'd0;
    localparam logic [2:0] ST_SUPPRESSED = 3'd1;
    localparam logic [2:0] ST_REJECTED = 3'd2;
    localparam logic [2:0] ST_REMOVED = 3'd3;
    localparam logic [2:0] ST_SENT_FULL = 3'd4;

    localparam logic CMD_ESTIMATE = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    localparam logic [0:0] CFG_MIN_INTERVAL = 1'd0;
    localparam logic [0:0] CFG_MIN_CHANGE = 1'd1;

    typedef struct packed {
        logic load;        // capture input transaction
        logic scan_start;  // reset scan index
        logic scan_step;   // compare one entry, advance
        logic rd_req;      // read payload of hit slot
        logic div_start;
        logic div_step;
        logic enc_step;
        logic wr_entry;    // record estimate in slot
        logic clr_entry;   // invalidate hit slot
    } retenc_cmd_t;

    typedef struct packed {
        logic is_remove;
        logic reject;
        logic scan_done;
        logic hit;
        logic has_free;
        logic div_done;
        logic enc_done;
        logic suppress;
    } retenc_stat_t;

endpackage

/* sv/retenc_datapath.sv */
// Datapath: input capture, table memories, scan, percent divider, encoder.
// Depends on retenc_pkg.
module retenc_datapath #(
    parameter int TABLE_DEPTH = retenc_pkg::TABLE_DEPTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  retenc_pkg::retenc_cmd_t   cmd_i,
    output retenc_pkg::retenc_stat_t  stat_o,
    input  logic                      cfg_we,
    input  logic [0:0]                cfg_idx,
    input  logic [15:0]               cfg_data,
    input  logic                      in_cmd,
    input  logic [31:0]               in_ssrc,
    input  logic [31:0]               in_kbps,
    input  logic [31:0]               in_now,
    output logic [2:0]                res_status,
    output logic                      res_send,
    output logic [5:0]                res_exp,
    output logic [17:0]               res_mant,
    output logic [31:0]               res_bps,
    output logic [31:0]               res_ssrc
);
    import retenc_pkg::*;

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic [15:0] min_int_reg;
    logic [6:0]  min_chg_reg;
    logic        cmd_reg;
    logic [31:0] ssrc_reg;
    logic [31:0] rate_reg;
    logic [31:0] now_reg;
    logic        reject_reg;

    logic [TABLE_DEPTH-1:0] valid_reg;
    logic [31:0] key_mem [TABLE_DEPTH];
    logic [31:0] bps_mem [TABLE_DEPTH];
    logic [31:0] ms_mem  [TABLE_DEPTH];
    logic [31:0] key_rd_reg;
    logic [31:0] old_bps_reg;
    logic [31:0] old_ms_reg;

    logic [CW-1:0] scan_reg;
    logic [IW-1:0] hit_idx_reg;
    logic          hit_reg;
    logic [IW-1:0] free_idx_reg;
    logic          free_reg;
    logic          cmp_pend_reg;
    logic [IW-1:0] cmp_idx_reg;

    logic [38:0] num_reg;
    logic [31:0] rem_reg;
    logic [6:0]  quo_reg;
    logic [5:0]  div_cnt_reg;
    logic [32:0] mant_reg;
    logic [5:0]  exp_reg;

    logic [31:0] kbps_sat;
    logic [31:0] delta;
    logic [32:0] rem_sh;
    logic [IW-1:0] scan_idx;

    assign kbps_sat = (in_kbps > KBPS_CAP) ? KBPS_CAP : in_kbps;
    assign delta = (old_bps_reg > rate_reg) ? old_bps_reg - rate_reg : rate_reg - old_bps_reg;
    assign rem_sh = {rem_reg, num_reg[38]};
    assign scan_idx = scan_reg[IW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_int_reg <= MIN_INTERVAL_RST;
            min_chg_reg <= MIN_CHANGE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                CFG_MIN_INTERVAL: min_int_reg <= cfg_data;
                CFG_MIN_CHANGE:   min_chg_reg <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            scan_reg     <= '0;
            hit_reg      <= 1'b0;
            free_reg     <= 1'b0;
            cmp_pend_reg <= 1'b0;
            div_cnt_reg  <= '0;
            hit_idx_reg  <= '0;
            free_idx_reg <= '0;
            cmp_idx_reg  <= '0;
        end
        else
        begin
            if (cmd_i.scan_start)
            begin
                scan_reg     <= '0;
                hit_reg      <= 1'b0;
                free_reg     <= 1'b0;
                cmp_pend_reg <= 1'b0;
            end
            else if (cmd_i.scan_step)
            begin
                cmp_pend_reg <= (scan_reg < CW'(TABLE_DEPTH));
                cmp_idx_reg  <= scan_idx;
                if (scan_reg < CW'(TABLE_DEPTH))
                begin
                    scan_reg <= scan_reg + 1'b1;
                    if (!valid_reg[scan_idx] && !free_reg)
                    begin
                        free_reg     <= 1'b1;
                        free_idx_reg <= scan_idx;
                    end
                end
                if (cmp_pend_reg && valid_reg[cmp_idx_reg] && key_rd_reg == ssrc_reg
                    && !hit_reg)
                begin
                    hit_reg     <= 1'b1;
                    hit_idx_reg <= cmp_idx_reg;
                end
            end
            if (cmd_i.wr_entry)
                valid_reg[hit_reg ? hit_idx_reg : free_idx_reg] <= 1'b1;
            if (cmd_i.clr_entry && hit_reg)
                valid_reg[hit_idx_reg] <= 1'b0;
            if (cmd_i.div_start)
                div_cnt_reg <= 6'd39;
            else if (cmd_i.div_step && div_cnt_reg != '0)
                div_cnt_reg <= div_cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_i.scan_step && scan_reg < CW'(TABLE_DEPTH))
            key_rd_reg <= key_mem[scan_idx];
        if (cmd_i.rd_req)
        begin
            old_bps_reg <= bps_mem[hit_idx_reg];
            old_ms_reg  <= ms_mem[hit_idx_reg];
        end
        if (cmd_i.wr_entry)
        begin
            key_mem[hit_reg ? hit_idx_reg : free_idx_reg] <= ssrc_reg;
            bps_mem[hit_reg ? hit_idx_reg : free_idx_reg] <= rate_reg;
            ms_mem[hit_reg ? hit_idx_reg : free_idx_reg]  <= now_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_i.load)
        begin
            cmd_reg    <= in_cmd;
            ssrc_reg   <= in_ssrc;
            rate_reg   <= kbps_sat * 32'd1000;
            now_reg    <= in_now;
            reject_reg <= (in_ssrc == '0) || (in_kbps == '0);
            mant_reg   <= {1'b0, kbps_sat * 32'd1000};
            exp_reg    <= '0;
        end
        else if (cmd_i.enc_step && mant_reg > {15'd0, MANT_MAX} && exp_reg < EXP_MAX)
        begin
            mant_reg <= (mant_reg + 33'd1) >> 1;
            exp_reg  <= exp_reg + 1'b1;
        end
        if (cmd_i.div_start)
        begin
            num_reg <= {delta, 7'd0} - {2'b0, delta, 5'd0} + {5'd0, delta, 2'd0};
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (cmd_i.div_step && div_cnt_reg != '0)
        begin
            num_reg <= {num_reg[37:0], 1'b0};
            if (rem_sh >= {1'b0, old_bps_reg})
            begin
                rem_reg <= 32'(rem_sh - {1'b0, old_bps_reg});
                quo_reg <= (quo_reg[6] || quo_reg == 7'd127) ? 7'd127 : {quo_reg[5:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh[31:0];
                quo_reg <= quo_reg[6] ? 7'd127 : {quo_reg[5:0], 1'b0};
            end
        end
    end

    logic suppress;
    assign suppress = hit_reg && (now_reg - old_ms_reg) < {16'd0, min_int_reg}
        && old_bps_reg != '0 && quo_reg < min_chg_reg;

    always_comb
    begin
        stat_o.is_remove = (cmd_reg == CMD_REMOVE);
        stat_o.reject    = reject_reg;
        stat_o.scan_done = (scan_reg == CW'(TABLE_DEPTH)) && !cmp_pend_reg;
        stat_o.hit       = hit_reg;
        stat_o.has_free  = free_reg;
        stat_o.div_done  = (div_cnt_reg == '0);
        stat_o.enc_done  = !(mant_reg > {15'd0, MANT_MAX} && exp_reg < EXP_MAX);
        stat_o.suppress  = suppress;
        res_ssrc = ssrc_reg;
        res_send = 1'b0;
        res_exp = '0;
        res_mant = '0;
        res_bps = '0;
        if (cmd_reg == CMD_REMOVE)
            res_status = ST_REMOVED;
        else if (reject_reg)
            res_status = ST_REJECTED;
        else if (suppress)
            res_status = ST_SUPPRESSED;
        else
        begin
            res_status = (hit_reg || free_reg) ? ST_SENT : ST_SENT_FULL;
            res_send = 1'b1;
            res_exp = exp_reg;
            res_mant = mant_reg[17:0];
            res_bps = rate_reg;
        end
    end
endmodule

/* sv/retenc_ctrl.sv */
// Controller state machine sequencing scan, divide, encode and result.
// Depends on retenc_pkg.
module retenc_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_fire,
    input  logic                      out_fire,
    input  retenc_pkg::retenc_stat_t  stat_i,
    output retenc_pkg::retenc_cmd_t   cmd_o,
    output logic                      in_rdy,
    output logic                      out_vld
);
    import retenc_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_READ = 3'd2;
    localparam logic [2:0] S_CALC = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd_o = '0;
        in_rdy = 1'b0;
        out_vld = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_rdy = 1'b1;
                if (in_fire)
                begin
                    cmd_o.load = 1'b1;
                    cmd_o.scan_start = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (!stat_i.is_remove && stat_i.reject)
                    state_next = S_DONE;
                else if (stat_i.scan_done)
                    state_next = S_READ;
                else
                    cmd_o.scan_step = 1'b1;
            end
            S_READ:
            begin
                cmd_o.rd_req = 1'b1;
                state_next = S_CALC;
            end
            S_CALC:
            begin
                cmd_o.div_start = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                cmd_o.div_step = 1'b1;
                cmd_o.enc_step = 1'b1;
                if (stat_i.div_done && stat_i.enc_done)
                begin
                    out_vld = 1'b1;
                    if (out_fire)
                    begin
                        cmd_o.clr_entry = stat_i.is_remove;
                        cmd_o.wr_entry = !stat_i.is_remove && !stat_i.reject
                            && !stat_i.suppress && (stat_i.hit || stat_i.has_free);
                        state_next = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end
endmodule

/* sv/remb_estimate_throttle_encoder_top.sv */
// Top level of the REMB estimate throttle and encoder.
// Depends on retenc_pkg, retenc_ctrl, retenc_datapath.
//
// Channel   Signals                                           Direction
// in        in_valid/in_ready, cmd, source_ssrc, bitrate_kbps, now_ms  input
// out       out_valid/out_ready, status, send, bitrate_exp, ...       output
// cfg       cfg_we, cfg_index, cfg_data                        input
//
// A transaction runs a linear table scan through the key memory port, then a
// 39-step restoring percent divider alongside the halving encoder. Rejected
// estimates skip the scan. Reset empties the table at once. A stalled result
// holds until taken.
module remb_estimate_throttle_encoder_top #(
    parameter int TABLE_DEPTH = retenc_pkg::TABLE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        cmd,
    input  logic [31:0] source_ssrc,
    input  logic [31:0] bitrate_kbps,
    input  logic [31:0] now_ms,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic        send,
    output logic [5:0]  bitrate_exp,
    output logic [17:0] bitrate_mantissa,
    output logic [31:0] bitrate_bps,
    output logic [31:0] target_ssrc
);
    import retenc_pkg::*;

    retenc_cmd_t  ctl_cmd;
    retenc_stat_t dp_stat;

    retenc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_valid && in_ready),
        .out_fire (out_valid && out_ready),
        .stat_i   (dp_stat),
        .cmd_o    (ctl_cmd),
        .in_rdy   (in_ready),
        .out_vld  (out_valid)
    );

    retenc_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_i      (ctl_cmd),
        .stat_o     (dp_stat),
        .cfg_we     (cfg_we),
        .cfg_idx    (cfg_index),
        .cfg_data   (cfg_data),
        .in_cmd     (cmd),
        .in_ssrc    (source_ssrc),
        .in_kbps    (bitrate_kbps),
        .in_now     (now_ms),
        .res_status (status),
        .res_send   (send),
        .res_exp    (bitrate_exp),
        .res_mant   (bitrate_mantissa),
        .res_bps    (bitrate_bps),
        .res_ssrc   (target_ssrc)
    );
endmodule

/* tb/sv/remb_estimate_throttle_encoder_top_test.sv */
// Testbench for the REMB estimate throttle and encoder: directed and random
// estimate/remove transactions checked against an in-bench table predictor.
// Depends on retenc_pkg and remb_estimate_throttle_encoder_top.
module remb_estimate_throttle_encoder_top_test;
    timeunit 1ns;
    timeprecision 1ps;
    import retenc_pkg::*;

    localparam int DEPTH = 64;

    typedef struct packed {
        logic [2:0]  status;
        logic        send;
        logic [5:0]  bitrate_exp;
        logic [17:0] bitrate_mantissa;
        logic [31:0] bitrate_bps;
        logic [31:0] target_ssrc;
    } remb_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [0:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic cmd = 1'b0;
    logic [31:0] source_ssrc = '0;
    logic [31:0] bitrate_kbps = '0;
    logic [31:0] now_ms = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [2:0] status;
    logic send;
    logic [5:0] bitrate_exp;
    logic [17:0] bitrate_mantissa;
    logic [31:0] bitrate_bps;
    logic [31:0] target_ssrc;

    remb_estimate_throttle_encoder_top uut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    logic [15:0] interval_ms;
    logic [6:0]  change_pct;
    bit          slot_used [DEPTH];
    logic [31:0] slot_key [DEPTH];
    logic [31:0] slot_bps [DEPTH];
    logic [31:0] slot_ms [DEPTH];
    remb_result_t pending_results[$];
    int errors = 0;
    int results_seen = 0;
    int sent_count = 0;
    int suppressed_count = 0;
    int full_count = 0;
    bit calm = 1'b0;
    logic [31:0] clock_ms = 32'd1000;
    logic [31:0] ssrc_pool [8];

    function automatic bit idle_now();
        return !calm && ($urandom_range(99) < 27);
    endfunction

    function automatic remb_result_t predict_remb(logic c, logic [31:0] ssrc,
                                                  logic [31:0] kbps, logic [31:0] now);
        remb_result_t r;
        int hit;
        int slot;
        logic [31:0] rate, old, delta, elapsed;
        logic [63:0] pct, m;
        bit go;
        r = '0;
        r.target_ssrc = ssrc;
        hit = -1;
        for (int i = 0; i < DEPTH; i++)
            if (hit < 0 && slot_used[i] && slot_key[i] == ssrc)
                hit = i;
        if (c == CMD_REMOVE) begin
            if (hit >= 0)
                slot_used[hit] = 1'b0;
            r.status = ST_REMOVED;
            return r;
        end
        if (ssrc == 0 || kbps == 0) begin
            r.status = ST_REJECTED;
            return r;
        end
        rate = ((kbps > KBPS_CAP) ? KBPS_CAP : kbps) * 32'd1000;
        go = 1'b1;
        if (hit >= 0) begin
            old = slot_bps[hit];
            elapsed = now - slot_ms[hit];
            delta = (old > rate) ? old - rate : rate - old;
            pct = (old == 0) ? 64'd100 : (64'(delta) * 100) / 64'(old);
            if (elapsed < 32'(interval_ms) && pct < 64'(change_pct))
                go = 1'b0;
        end
        if (!go) begin
            r.status = ST_SUPPRESSED;
            return r;
        end
        slot = hit;
        if (slot < 0)
            for (int i = DEPTH - 1; i >= 0; i--)
                if (!slot_used[i])
                    slot = i;
        if (slot >= 0) begin
            slot_used[slot] = 1'b1;
            slot_key[slot] = ssrc;
            slot_bps[slot] = rate;
            slot_ms[slot] = now;
            r.status = ST_SENT;
        end else begin
            r.status = ST_SENT_FULL;
        end
        m = 64'(rate);
        r.bitrate_exp = 0;
        while (m > 64'(MANT_MAX) && r.bitrate_exp < EXP_MAX) begin
            m = (m + 1) >> 1;
            r.bitrate_exp++;
        end
        r.bitrate_mantissa = m[17:0];
        r.send = 1'b1;
        r.bitrate_bps = rate;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    always @(posedge clk)
    begin
        remb_result_t want;
        if (out_valid && out_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result for ssrc", target_ssrc, 32'd0);
            end else begin
                want = pending_results.pop_front();
                if (status != want.status) report_mismatch("status", status, want.status);
                if (send != want.send) report_mismatch("send", send, want.send);
                if (bitrate_exp != want.bitrate_exp)
                    report_mismatch("bitrate_exp", bitrate_exp, want.bitrate_exp);
                if (bitrate_mantissa != want.bitrate_mantissa)
                    report_mismatch("bitrate_mantissa", bitrate_mantissa,
                                    want.bitrate_mantissa);
                if (bitrate_bps != want.bitrate_bps)
                    report_mismatch("bitrate_bps", bitrate_bps, want.bitrate_bps);
                if (target_ssrc != want.target_ssrc)
                    report_mismatch("target_ssrc", target_ssrc, want.target_ssrc);
                if (want.status == ST_SENT) sent_count++;
                if (want.status == ST_SUPPRESSED) suppressed_count++;
                if (want.status == ST_SENT_FULL) full_count++;
            end
        end
    end

    always @(negedge clk)
        out_ready <= !idle_now();

    task automatic send_request(logic c, logic [31:0] ssrc, logic [31:0] kbps,
                                logic [31:0] now);
        do
            @(negedge clk);
        while (idle_now());
        cmd <= c;
        source_ssrc <= ssrc;
        bitrate_kbps <= kbps;
        now_ms <= now;
        in_valid <= 1'b1;
        pending_results.insert(pending_results.size(), predict_remb(c, ssrc, kbps, now));
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (150)
            @(negedge clk);
    endtask

    task automatic write_config(logic [0:0] idx, logic [15:0] value);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_MIN_INTERVAL)
            interval_ms = value;
        else
            change_pct = value[6:0];
    endtask

    task automatic clear_table();
        for (int i = 0; i < DEPTH; i++)
            if (slot_used[i])
                send_request(CMD_REMOVE, slot_key[i], $urandom, $urandom);
    endtask

    task automatic test_directed();
        send_request(CMD_ESTIMATE, 32'd0, 32'd100, 32'd0);
        send_request(CMD_ESTIMATE, 32'd7, 32'd0, 32'd0);
        send_request(CMD_REMOVE, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(CMD_REMOVE, 32'd99, 32'd5, 32'd5);
        send_request(CMD_ESTIMATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFF0);
        send_request(CMD_ESTIMATE, 32'hFFFF_FFFF, 32'd4294966, 32'd10);
        send_request(CMD_ESTIMATE, 32'hFFFF_FFFF, 32'd4000000, 32'd20);
        send_request(CMD_ESTIMATE, 32'd1, 32'd1, 32'd100);
        send_request(CMD_ESTIMATE, 32'd1, 32'd262, 32'd101);
        send_request(CMD_ESTIMATE, 32'd1, 32'd263, 32'd102);
        send_request(CMD_ESTIMATE, 32'd1, 32'd264, 32'd700);
        send_request(CMD_ESTIMATE, 32'd1, 32'd264, 32'd701);
        send_request(CMD_REMOVE, 32'd1, 32'd0, 32'd0);
        send_request(CMD_ESTIMATE, 32'd1, 32'd264, 32'd702);
        send_request(CMD_ESTIMATE, 32'd2, 32'h8000_0000, 32'h5555_5555);
        send_request(CMD_ESTIMATE, 32'd3, 32'd4294968, 32'hAAAA_AAAA);
    endtask

    task automatic test_table_full();
        clear_table();
        for (int i = 0; i < DEPTH + 3; i++)
            send_request(CMD_ESTIMATE, 32'h100 + i, $urandom_range(1, 5000), clock_ms);
        send_request(CMD_REMOVE, 32'h100 + 5, 32'd0, 32'd0);
        send_request(CMD_ESTIMATE, 32'h900, 32'd77, clock_ms);
        send_request(CMD_ESTIMATE, 32'h901, 32'd78, clock_ms);
        clear_table();
    endtask

    task automatic random_phase(int count);
        logic [31:0] s, k;
        int pick;
        for (int i = 0; i < 8; i++)
            ssrc_pool[i] = $urandom;
        for (int i = 0; i < count; i++) begin
            calm = (i % 300) >= 240;
            clock_ms += $urandom_range(0, 2 * interval_ms + 2);
            pick = $urandom_range(99);
            s = ssrc_pool[$urandom_range(7)];
            if (pick < 3)
                s = 0;
            else if (pick < 8)
                s = $urandom;
            k = $urandom_range(1, 20000);
            if (pick % 10 == 0)
                k = $urandom;
            else if (pick % 17 == 0)
                k = 0;
            if (pick >= 93)
                send_request(CMD_REMOVE, s, $urandom, $urandom);
            else if (pick >= 85)
                send_request(CMD_ESTIMATE, s, k, $urandom);
            else
                send_request(CMD_ESTIMATE, s, k, clock_ms);
        end
        calm = 1'b0;
    endtask

    task automatic test_settings();
        write_config(CFG_MIN_INTERVAL, 16'd0);
        write_config(CFG_MIN_CHANGE, 16'd0);
        random_phase(150);
        write_config(CFG_MIN_INTERVAL, 16'hFFFF);
        write_config(CFG_MIN_CHANGE, 16'd100);
        random_phase(250);
        write_config(CFG_MIN_CHANGE, 16'hFF80 | 16'd127);
        random_phase(150);
        write_config(CFG_MIN_INTERVAL, 16'd300);
        write_config(CFG_MIN_CHANGE, 16'd10);
        random_phase(300);
        write_config(CFG_MIN_INTERVAL, 16'h5A5A);
        write_config(CFG_MIN_CHANGE, 16'd1);
        random_phase(150);
    endtask

    initial
    begin
        interval_ms = MIN_INTERVAL_RST;
        change_pct = MIN_CHANGE_RST;
        for (int i = 0; i < DEPTH; i++)
            slot_used[i] = 1'b0;
        repeat (9)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        random_phase(150);
        test_table_full();
        test_settings();
        drain();
        $display("covered %0d results: %0d sent, %0d suppressed, %0d sent with table full",
                 results_seen, sent_count, suppressed_count, full_count);
        if (errors == 0)
            $display("remb_estimate_throttle_encoder_top_test passed");
        else
            $display("remb_estimate_throttle_encoder_top_test failed");
        $finish;
    end

    initial
    begin
        #30ms;
        $display("remb_estimate_throttle_encoder_top_test failed");
        $finish;
    end
endmodule

/* sim.f */
sv/retenc_pkg.sv
sv/retenc_datapath.sv
sv/retenc_ctrl.sv
sv/remb_estimate_throttle_encoder_top.sv
tb/sv/remb_estimate_throttle_encoder_top_test.sv
